### hdl/momentum_oscillator_events_unit_defines.svh
// ----------------------------------------------------------------------------
// momentum oscillator events unit assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef MOMENTUM_OSCILLATOR_EVENTS_UNIT_DEFINES_SVH
`define MOMENTUM_OSCILLATOR_EVENTS_UNIT_DEFINES_SVH

// same-cycle implication
`define MOE_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("moe check failed");

// next-cycle implication
`define MOE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("moe check failed");

`endif

### hdl/moe_pkg.sv
// ----------------------------------------------------------------------------
// moe_pkg
// types and fixed widths shared by the momentum oscillator events unit
// ----------------------------------------------------------------------------
package moe_pkg;

  localparam int OSC_W       = 16;
  localparam int QUO_W       = 15;
  localparam int DIV_CNT_W   = 4;
  localparam int CNT_W       = 32;
  localparam int WIN_REG_W   = 7;
  localparam int LEVEL_W     = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_TDATA_W = 120;

  // 25600 = 2^14 + 2^13 + 2^10
  localparam int SCALE_SH_A = 14;
  localparam int SCALE_SH_B = 13;
  localparam int SCALE_SH_C = 10;

  localparam logic [WIN_REG_W-1:0] WINDOW_RESET     = 7'd14;
  localparam logic [WIN_REG_W-1:0] MIN_SAMPLES_RESET = 7'd14;
  localparam logic signed [LEVEL_W-1:0] OVERBOUGHT_RESET = 16'sd12800;
  localparam logic signed [LEVEL_W-1:0] OVERSOLD_RESET   = -16'sd12800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 8'd0,
    CFG_MIN_SAMPLES   = 8'd1,
    CFG_OVERBOUGHT    = 8'd2,
    CFG_OVERSOLD      = 8'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_PREV,
    ST_RD_OLD,
    ST_RD_NEXT,
    ST_UPDATE,
    ST_PREP1,
    ST_PREP2,
    ST_DIV,
    ST_EVAL,
    ST_OUT
  } moe_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### hdl/moe_ram.sv
// ----------------------------------------------------------------------------
// moe_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module moe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/moe_divider.sv
// ----------------------------------------------------------------------------
// moe_divider
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
module moe_divider #(
  parameter int DEN_W = 30
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [DEN_W+moe_pkg::QUO_W-1:0] num,
  input  logic [DEN_W-1:0]                den,
  output logic [moe_pkg::QUO_W-1:0]       quot,
  output moe_pkg::div_status_t            status
);

  import moe_pkg::*;

  localparam int NUM_W = DEN_W + QUO_W;

  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dsr;
  logic [QUO_W-1:0]     low;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       trial_sub;
  logic                 ge;

  assign trial     = {rem, low[QUO_W-1]};
  assign ge        = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else if (start) begin
      rem         <= num[NUM_W-1:QUO_W];
      low         <= num[QUO_W-1:0];
      dsr         <= den;
      quot        <= '0;
      cnt         <= DIV_CNT_W'(QUO_W);
      status.busy <= 1'b1;
      status.done <= 1'b0;
    end else if (status.busy) begin
      rem  <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      low  <= {low[QUO_W-2:0], 1'b0};
      quot <= {quot[QUO_W-2:0], ge};
      cnt  <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end else begin
      status.done <= 1'b0;
    end
  end

endmodule

### hdl/momentum_oscillator_events_unit.sv
// ----------------------------------------------------------------------------
// momentum oscillator events unit
// a computed item with movement passes through the 15-step divider before its result,
// and the next item is taken only after the result has been handed to the output
// zero movement skips the divider
// an item that does not compute skips the oscillator steps and goes straight to output
// synchronous reset returns to idle, clears the ring, sums, flags and counters and loads the register defaults
// ----------------------------------------------------------------------------
module momentum_oscillator_events_unit #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [SAMPLE_BITS-1:0] sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [15:0] oscillator, [16] computed, [17] in_overbought, [18] in_oversold,
  // [19] overbought_fired, [20] oversold_fired, [52:21] overbought_count,
  // [84:53] oversold_count, [116:85] item_count
  output logic [moe_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [moe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [moe_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import moe_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW + 1);
  localparam int CW    = $clog2(MAX_WINDOW + 2);
  localparam int XW    = (CW > 8) ? CW : 8;
  localparam int SB    = SAMPLE_BITS;
  localparam int DIF_W = SAMPLE_BITS + 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int NUM_W = SUM_W + QUO_W;

  moe_state_t state, state_next;

  // configuration
  logic [WIN_REG_W-1:0]      win_len;
  logic [WIN_REG_W-1:0]      min_smp;
  logic signed [LEVEL_W-1:0] ob_lvl;
  logic signed [LEVEL_W-1:0] os_lvl;

  // ring and sums
  logic signed [SB-1:0]    smp;
  logic signed [SB-1:0]    old_s;
  logic signed [DIF_W-1:0] dnew;
  logic [AW-1:0]           head;
  logic [CW-1:0]           fill;
  logic [SUM_W-1:0]        rise;
  logic [SUM_W-1:0]        fall;
  logic [SUM_W-1:0]        den;
  logic signed [SUM_W:0]   dif;
  logic                    neg;
  logic                    comp;
  logic signed [OSC_W-1:0] osc_new;

  // result state
  logic signed [OSC_W-1:0] last_osc;
  logic                    ob_flag;
  logic                    os_flag;
  logic [CNT_W-1:0]        ob_cnt;
  logic [CNT_W-1:0]        os_cnt;
  logic [CNT_W-1:0]        rec_cnt;

  // sequencer controls
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [SB-1:0] ram_rdata;
  logic          div_start;
  div_status_t   div_st;
  logic [QUO_W-1:0] quot;
  logic          out_free;

  // window geometry
  logic [XW-1:0] win_ext;
  logic [XW-1:0] eff_w;
  logic [CW-1:0] depth;
  logic [XW-1:0] need_raw;
  logic [XW-1:0] need;
  logic [AW-1:0] head_prev;
  logic [AW-1:0] head_next;
  logic          full;
  logic [CW-1:0] fill_new;
  logic          do_comp;

  assign win_ext  = XW'(win_len);
  assign eff_w    = (win_ext < XW'(2)) ? XW'(2) :
                    (win_ext > XW'(MAX_WINDOW)) ? XW'(MAX_WINDOW) : win_ext;
  assign depth    = CW'(eff_w + XW'(1));
  assign need_raw = XW'(min_smp) + XW'(1);
  assign need     = (need_raw < XW'(2)) ? XW'(2) : need_raw;
  assign head_prev = (head == '0) ? AW'(depth - CW'(1)) : head - AW'(1);
  assign head_next = ((CW'(head) + CW'(1)) == depth) ? '0 : head + AW'(1);
  assign full     = (fill == depth);
  assign fill_new = full ? fill : fill + CW'(1);
  assign do_comp  = XW'(fill_new) >= need;

  // difference bookkeeping
  logic signed [DIF_W-1:0] dold;
  logic signed [DIF_W-1:0] dnew_neg;
  logic signed [DIF_W-1:0] dold_neg;
  logic [SUM_W-1:0]        rise_add, fall_add, rise_sub, fall_sub;
  logic                    have_prev;

  assign dold      = $signed({ram_rdata[SB-1], ram_rdata}) - $signed({old_s[SB-1], old_s});
  assign dnew_neg  = -dnew;
  assign dold_neg  = -dold;
  assign have_prev = (fill != '0);
  assign rise_add  = (have_prev && !dnew[DIF_W-1] && dnew != '0) ?
                     SUM_W'(dnew[SB-1:0]) : '0;
  assign fall_add  = (have_prev && dnew[DIF_W-1]) ? SUM_W'(dnew_neg[SB-1:0]) : '0;
  assign rise_sub  = (full && !dold[DIF_W-1] && dold != '0) ?
                     SUM_W'(dold[SB-1:0]) : '0;
  assign fall_sub  = (full && dold[DIF_W-1]) ? SUM_W'(dold_neg[SB-1:0]) : '0;

  // scaled numerator
  logic signed [SUM_W:0] dif_neg;
  logic [SUM_W-1:0]      mag;
  logic [NUM_W-1:0]      mag_x;
  logic [NUM_W-1:0]      num;

  assign dif_neg = -dif;
  assign mag     = dif[SUM_W] ? dif_neg[SUM_W-1:0] : dif[SUM_W-1:0];
  assign mag_x   = NUM_W'(mag);
  assign num     = (mag_x << SCALE_SH_A) + (mag_x << SCALE_SH_B) + (mag_x << SCALE_SH_C);

  // result assembly
  logic                    cur_ob, cur_os, fire_ob, fire_os, ob_flag_n, os_flag_n;
  logic signed [OSC_W-1:0] last_osc_n;
  logic [CNT_W-1:0]        ob_cnt_n, os_cnt_n, rec_cnt_n;
  logic signed [OSC_W-1:0] q_ext;

  assign q_ext      = OSC_W'(quot);
  assign cur_ob     = osc_new > ob_lvl;
  assign cur_os     = osc_new < os_lvl;
  assign fire_ob    = comp && cur_ob && !ob_flag;
  assign fire_os    = comp && cur_os && !os_flag;
  assign ob_flag_n  = comp ? cur_ob : ob_flag;
  assign os_flag_n  = comp ? cur_os : os_flag;
  assign last_osc_n = comp ? osc_new : last_osc;
  assign ob_cnt_n   = (fire_ob && ob_cnt != '1) ? ob_cnt + CNT_W'(1) : ob_cnt;
  assign os_cnt_n   = (fire_os && os_cnt != '1) ? os_cnt + CNT_W'(1) : os_cnt;
  assign rec_cnt_n  = (rec_cnt != '1) ? rec_cnt + CNT_W'(1) : rec_cnt;
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  moe_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WINDOW + 1)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (head),
    .wr_data (smp),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  moe_divider #(
    .DEN_W (SUM_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (num),
    .den    (den),
    .quot   (quot),
    .status (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ram_we        = 1'b0;
    ram_raddr     = head;
    div_start     = 1'b0;
    s_axis_tready = 1'b0;
    cfg_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cfg_ready     = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_RD_PREV;
        end
      end
      ST_RD_PREV: begin
        ram_raddr  = head_prev;
        state_next = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        ram_raddr  = head;
        state_next = ST_RD_NEXT;
      end
      ST_RD_NEXT: begin
        ram_raddr  = head_next;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_we     = 1'b1;
        state_next = do_comp ? ST_PREP1 : ST_OUT;
      end
      ST_PREP1: begin
        state_next = ST_PREP2;
      end
      ST_PREP2: begin
        if (den == '0) begin
          state_next = ST_EVAL;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len       <= WINDOW_RESET;
      min_smp       <= MIN_SAMPLES_RESET;
      ob_lvl        <= OVERBOUGHT_RESET;
      os_lvl        <= OVERSOLD_RESET;
      head          <= '0;
      fill          <= '0;
      rise          <= '0;
      fall          <= '0;
      last_osc      <= '0;
      ob_flag       <= 1'b0;
      os_flag       <= 1'b0;
      ob_cnt        <= '0;
      os_cnt        <= '0;
      rec_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          smp <= s_axis_tdata[SB-1:0];
          if (cfg_valid) begin
            priority case (cfg_index)
              CFG_WINDOW_LENGTH: win_len <= cfg_data[WIN_REG_W-1:0];
              CFG_MIN_SAMPLES:   min_smp <= cfg_data[WIN_REG_W-1:0];
              CFG_OVERBOUGHT:    ob_lvl  <= cfg_data[LEVEL_W-1:0];
              CFG_OVERSOLD:      os_lvl  <= cfg_data[LEVEL_W-1:0];
              default: ;
            endcase
            if (cfg_index == CFG_WINDOW_LENGTH || cfg_index == CFG_MIN_SAMPLES ||
                cfg_index == CFG_OVERBOUGHT || cfg_index == CFG_OVERSOLD) begin
              head     <= '0;
              fill     <= '0;
              rise     <= '0;
              fall     <= '0;
              last_osc <= '0;
              ob_flag  <= 1'b0;
              os_flag  <= 1'b0;
              ob_cnt   <= '0;
              os_cnt   <= '0;
              rec_cnt  <= '0;
            end
          end
        end
        ST_RD_OLD: begin
          dnew <= $signed({smp[SB-1], smp}) - $signed({ram_rdata[SB-1], ram_rdata});
        end
        ST_RD_NEXT: begin
          old_s <= ram_rdata;
        end
        ST_UPDATE: begin
          rise <= rise + rise_add - rise_sub;
          fall <= fall + fall_add - fall_sub;
          fill <= fill_new;
          head <= head_next;
          comp <= do_comp;
        end
        ST_PREP1: begin
          den <= rise + fall;
          dif <= $signed({1'b0, rise}) - $signed({1'b0, fall});
        end
        ST_PREP2: begin
          neg <= dif[SUM_W];
        end
        ST_EVAL: begin
          osc_new <= (den == '0) ? '0 : (neg ? -q_ext : q_ext);
        end
        ST_OUT: begin
          if (out_free) begin
            last_osc      <= last_osc_n;
            ob_flag       <= ob_flag_n;
            os_flag       <= os_flag_n;
            ob_cnt        <= ob_cnt_n;
            os_cnt        <= os_cnt_n;
            rec_cnt       <= rec_cnt_n;
            m_axis_tdata  <= {3'b000, rec_cnt_n, os_cnt_n, ob_cnt_n, fire_os, fire_ob,
                              os_flag_n, ob_flag_n, comp, last_osc_n};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hdl/moe_checker.sv
// ----------------------------------------------------------------------------
// moe_checker
// port-level checks on the momentum oscillator events unit
// ----------------------------------------------------------------------------
`include "momentum_oscillator_events_unit_defines.svh"

module moe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [moe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            cfg_ready
);

  import moe_pkg::*;

  // one request in flight at a time
  `MOE_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // config is only taken while the sample side is open
  `MOE_ASSERT_NOW(a_cfg_when_idle, clk, rst, cfg_ready, s_axis_tready)

  // an entry event needs a new value that lies in the region
  `MOE_ASSERT_NOW(a_ob_fire, clk, rst, m_axis_tvalid && m_axis_tdata[19], m_axis_tdata[16] && m_axis_tdata[17])
  `MOE_ASSERT_NOW(a_os_fire, clk, rst, m_axis_tvalid && m_axis_tdata[20], m_axis_tdata[16] && m_axis_tdata[18])

endmodule

bind momentum_oscillator_events_unit moe_checker u_moe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);
